// ----- sv/fbde_pkg.sv -----
// ============================================================================
// fbde_pkg
// Shared types, codes and constants of the framebuffer draw engine.
// ============================================================================
package fbde_pkg;

    localparam int unsigned DEF_MAX_WIDTH  = 800;
    localparam int unsigned DEF_MAX_HEIGHT = 600;
    localparam int unsigned COORD_W        = 10;
    localparam int unsigned COLOR_W        = 8;
    localparam int unsigned FRAC_W         = 16;

    // command codes
    typedef enum logic [1:0] {
        OP_FILL = 2'd0,
        OP_SET  = 2'd1,
        OP_GET  = 2'd2,
        OP_LINE = 2'd3
    } t_opcode;

    // configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // classified job handed from front to back
    typedef enum logic [2:0] {
        JOB_FILL,
        JOB_SET,
        JOB_GET,
        JOB_VLINE,
        JOB_HLINE,
        JOB_SLINE,
        JOB_OOR
    } t_job_kind;

    typedef struct packed {
        t_job_kind            kind;
        logic [COORD_W-1:0]   xa;
        logic [COORD_W-1:0]   ya;
        logic [COORD_W-1:0]   xb;
        logic [COORD_W-1:0]   yb;
        logic [COLOR_W-1:0]   color;
    } t_job;

    // back-end sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_RUN,
        ST_ADDR,
        ST_RD,
        ST_RDWAIT,
        ST_OUT
    } t_be_state;

endpackage

// ----- sv/framebuffer_draw_engine_core.sv -----
// ============================================================================
// framebuffer_draw_engine_core
// 8-bit framebuffer engine: fill, set pixel, get pixel and line draw.
// ============================================================================
// A front end checks each command against the screen size, orders line
// endpoints and queues up to two jobs; a back end runs them on a single-port
// frame store (one access a cycle). After reset all MAX_WIDTH*MAX_HEIGHT
// entries of the store are swept to zero before the first command runs. Fill
// writes width*height pixels. Sloped lines first run the serial slope
// divider, then take each pixel through row multiply, address and write.
module framebuffer_draw_engine_core #(
    parameter int unsigned MAX_WIDTH  = fbde_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = fbde_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_opcode,
    input  logic [fbde_pkg::COORD_W-1:0]  i_x_start,
    input  logic [fbde_pkg::COORD_W-1:0]  i_y_start,
    input  logic [fbde_pkg::COORD_W-1:0]  i_x_end,
    input  logic [fbde_pkg::COORD_W-1:0]  i_y_end,
    input  logic [fbde_pkg::COLOR_W-1:0]  i_color,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_status,
    output logic [fbde_pkg::COLOR_W-1:0]  o_read_color,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [fbde_pkg::COORD_W-1:0]  i_cfg_data
);

    localparam int unsigned CW = fbde_pkg::COORD_W;
    localparam logic [CW+1:0] MW = (CW+2)'(MAX_WIDTH);
    localparam logic [CW+1:0] MH = (CW+2)'(MAX_HEIGHT);

    logic [CW-1:0]   r_width;
    logic [CW-1:0]   r_height;
    logic [CW-1:0]   w_eff_w;
    logic [CW-1:0]   w_eff_h;
    logic            w_job_valid;
    logic            w_job_take;
    fbde_pkg::t_job  w_job;

    assign o_cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CW'(800);
            r_height <= CW'(600);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == fbde_pkg::REG_WIDTH) r_width  <= i_cfg_data;
            else                                    r_height <= i_cfg_data;
        end
    end

    // saturate to the store geometry
    assign w_eff_w = ({2'b00, r_width}  > MW) ? MW[CW-1:0] : r_width;
    assign w_eff_h = ({2'b00, r_height} > MH) ? MH[CW-1:0] : r_height;

    fbde_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_opcode, .i_x_start, .i_y_start, .i_x_end, .i_y_end, .i_color,
        .i_eff_w(w_eff_w), .i_eff_h(w_eff_h),
        .o_job_valid(w_job_valid), .i_job_take(w_job_take), .o_job(w_job)
    );

    fbde_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(w_job_valid), .o_job_take(w_job_take), .i_job(w_job),
        .i_eff_w(w_eff_w), .i_eff_h(w_eff_h),
        .o_valid, .i_stall, .o_status, .o_read_color
    );

endmodule

// ----- sv/fbde_front.sv -----
// ============================================================================
// fbde_front
// Accepts commands, checks range, orders endpoints and classifies the job
// into a two-entry queue.
// ============================================================================
module fbde_front #(
    parameter int unsigned MAX_WIDTH  = fbde_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = fbde_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_opcode,
    input  logic [fbde_pkg::COORD_W-1:0]  i_x_start,
    input  logic [fbde_pkg::COORD_W-1:0]  i_y_start,
    input  logic [fbde_pkg::COORD_W-1:0]  i_x_end,
    input  logic [fbde_pkg::COORD_W-1:0]  i_y_end,
    input  logic [fbde_pkg::COLOR_W-1:0]  i_color,
    input  logic [fbde_pkg::COORD_W-1:0]  i_eff_w,
    input  logic [fbde_pkg::COORD_W-1:0]  i_eff_h,
    output logic                          o_job_valid,
    input  logic                          i_job_take,
    output fbde_pkg::t_job                o_job
);

    fbde_pkg::t_job r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    fbde_pkg::t_job n_job;
    logic           w_push;
    logic           w_pop;
    logic           w_on_s;
    logic           w_on_e;
    logic           w_swap;

    assign o_stall     = (r_cnt == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign o_job_valid = (r_cnt != 2'd0);
    assign w_pop       = o_job_valid && i_job_take;
    assign o_job       = r_q[r_rp];

    // classify
    always_comb begin
        w_on_s = (i_x_start < i_eff_w) && (i_y_start < i_eff_h);
        w_on_e = (i_x_end < i_eff_w) && (i_y_end < i_eff_h);
        w_swap = (i_x_end < i_x_start);
        n_job.color = i_color;
        n_job.xa = w_swap ? i_x_end : i_x_start;
        n_job.ya = w_swap ? i_y_end : i_y_start;
        n_job.xb = w_swap ? i_x_start : i_x_end;
        n_job.yb = w_swap ? i_y_start : i_y_end;
        case (fbde_pkg::t_opcode'(i_opcode))
            fbde_pkg::OP_FILL: n_job.kind = fbde_pkg::JOB_FILL;
            fbde_pkg::OP_SET:
                n_job.kind = w_on_s ? fbde_pkg::JOB_SET : fbde_pkg::JOB_OOR;
            fbde_pkg::OP_GET:
                n_job.kind = w_on_s ? fbde_pkg::JOB_GET : fbde_pkg::JOB_OOR;
            fbde_pkg::OP_LINE: begin
                if (!(w_on_s && w_on_e)) n_job.kind = fbde_pkg::JOB_OOR;
                else if (i_x_start == i_x_end) n_job.kind = fbde_pkg::JOB_VLINE;
                else if (i_y_start == i_y_end) n_job.kind = fbde_pkg::JOB_HLINE;
                else n_job.kind = fbde_pkg::JOB_SLINE;
            end
            default: n_job.kind = fbde_pkg::JOB_OOR;
        endcase
        // non-line commands use the start point as given
        if (i_opcode != fbde_pkg::OP_LINE) begin
            n_job.xa = i_x_start;
            n_job.ya = i_y_start;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= n_job;
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

// ----- sv/fbde_back.sv -----
// ============================================================================
// fbde_back
// Carries out jobs against the frame store: clear sweep, fill, pixel set/get,
// line runs and sloped lines with a serial divider and a registered multiply.
// ============================================================================
module fbde_back #(
    parameter int unsigned MAX_WIDTH  = fbde_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = fbde_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    output logic                          o_job_take,
    input  fbde_pkg::t_job                i_job,
    input  logic [fbde_pkg::COORD_W-1:0]  i_eff_w,
    input  logic [fbde_pkg::COORD_W-1:0]  i_eff_h,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_status,
    output logic [fbde_pkg::COLOR_W-1:0]  o_read_color
);

    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = fbde_pkg::COORD_W;
    localparam int unsigned SW    = CW + fbde_pkg::FRAC_W + 1;  // signed slope
    localparam int unsigned DIVW  = CW + fbde_pkg::FRAC_W;       // |dy|<<16
    localparam int unsigned DCW   = $clog2(DIVW + 1);
    localparam int unsigned ACCW  = SW + CW + 1;

    logic [fbde_pkg::COLOR_W-1:0] r_mem [DEPTH];

    fbde_pkg::t_be_state r_st, n_st;
    fbde_pkg::t_job      r_job;
    logic [AW:0]         r_cnt;       // clear / fill counter
    logic [AW-1:0]       r_addr;
    logic [CW-1:0]       r_i;         // walking coordinate
    logic [CW-1:0]       r_end;
    logic [DIVW-1:0]     r_quo;       // divider quotient / dividend shift
    logic [CW:0]         r_rem;
    logic [DCW-1:0]      r_dcnt;
    logic                r_neg;
    logic signed [SW-1:0] r_slope;
    logic signed [ACCW-1:0] r_acc;    // ya<<16 + slope*(i-xa), accumulated
    logic [AW-1:0]       r_mul;       // row * width product register
    logic                r_ovalid;
    logic                r_ostat;
    logic [fbde_pkg::COLOR_W-1:0] r_ocolor;
    logic [fbde_pkg::COLOR_W-1:0] r_rdata;

    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [AW:0]         w_total;
    logic [CW:0]         w_rem_sh;
    logic [CW-1:0]       w_dx;
    logic [CW-1:0]       w_ady;
    logic [CW-1:0]       w_ypix;
    logic                w_take;
    logic                w_done_out;

    assign w_total = (AW+1)'(i_eff_w) * (AW+1)'(i_eff_h);
    assign w_dx    = r_job.xb - r_job.xa;
    assign w_ady   = (r_job.yb > r_job.ya) ? r_job.yb - r_job.ya : r_job.ya - r_job.yb;
    assign w_rem_sh = {r_rem[CW-1:0], r_quo[DIVW-1]};
    assign w_ypix  = r_acc[ACCW-1] ? '0 : r_acc[fbde_pkg::FRAC_W +: CW];
    assign w_take  = (r_st == fbde_pkg::ST_IDLE) && i_job_valid && !r_ovalid;
    assign o_job_take = w_take;
    assign w_done_out = r_ovalid && !i_stall;

    assign o_valid      = r_ovalid;
    assign o_status     = r_ostat;
    assign o_read_color = r_ocolor;

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            fbde_pkg::ST_CLEAR: if (r_cnt == (AW+1)'(DEPTH - 1)) n_st = fbde_pkg::ST_IDLE;
            fbde_pkg::ST_IDLE: if (w_take) begin
                case (i_job.kind)
                    fbde_pkg::JOB_FILL:
                        n_st = (w_total == '0) ? fbde_pkg::ST_OUT : fbde_pkg::ST_RUN;
                    fbde_pkg::JOB_SET, fbde_pkg::JOB_GET, fbde_pkg::JOB_VLINE,
                    fbde_pkg::JOB_HLINE: n_st = fbde_pkg::ST_MUL;
                    fbde_pkg::JOB_SLINE: n_st = fbde_pkg::ST_DIV;
                    default: n_st = fbde_pkg::ST_OUT;
                endcase
            end
            fbde_pkg::ST_DIV: if (r_dcnt == DCW'(DIVW - 1)) n_st = fbde_pkg::ST_MUL;
            fbde_pkg::ST_MUL: n_st = fbde_pkg::ST_ADDR;
            fbde_pkg::ST_ADDR: n_st = (r_job.kind == fbde_pkg::JOB_GET) ?
                                      fbde_pkg::ST_RD : fbde_pkg::ST_RUN;
            fbde_pkg::ST_RUN: begin
                if (r_job.kind == fbde_pkg::JOB_FILL) begin
                    if (r_cnt == w_total - 1'b1) n_st = fbde_pkg::ST_OUT;
                end else if (r_job.kind == fbde_pkg::JOB_SET || r_i == r_end) begin
                    n_st = fbde_pkg::ST_OUT;
                end else if (r_job.kind == fbde_pkg::JOB_SLINE) begin
                    n_st = fbde_pkg::ST_MUL;
                end
            end
            fbde_pkg::ST_RD:     n_st = fbde_pkg::ST_RDWAIT;
            fbde_pkg::ST_RDWAIT: n_st = fbde_pkg::ST_OUT;
            fbde_pkg::ST_OUT:    n_st = fbde_pkg::ST_IDLE;
            default:             n_st = fbde_pkg::ST_IDLE;
        endcase
    end

    // memory write control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        case (r_st)
            fbde_pkg::ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_cnt[AW-1:0];
            end
            fbde_pkg::ST_RUN: begin
                w_we    = 1'b1;
                w_waddr = (r_job.kind == fbde_pkg::JOB_FILL) ? r_cnt[AW-1:0] : r_addr;
            end
            default: w_we = 1'b0;
        endcase
    end

    // frame store
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= (r_st == fbde_pkg::ST_CLEAR) ? '0 : r_job.color;
        r_rdata <= r_mem[r_addr];
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= fbde_pkg::ST_CLEAR;
        else          r_st <= n_st;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_done_out) r_ovalid <= 1'b0;
            case (r_st)
                fbde_pkg::ST_CLEAR: r_cnt <= r_cnt + 1'b1;
                fbde_pkg::ST_IDLE: if (w_take) begin
                    r_job  <= i_job;
                    r_cnt  <= '0;
                    r_dcnt <= '0;
                    r_ostat <= (i_job.kind == fbde_pkg::JOB_OOR);
                    r_ocolor <= '0;
                    r_i   <= (i_job.kind == fbde_pkg::JOB_VLINE) ?
                             ((i_job.ya < i_job.yb) ? i_job.ya : i_job.yb) : i_job.xa;
                    r_end <= (i_job.kind == fbde_pkg::JOB_VLINE) ?
                             ((i_job.ya < i_job.yb) ? i_job.yb : i_job.ya) : i_job.xb;
                    r_rem <= '0;
                    r_quo <= '0;
                    r_acc <= ACCW'(i_job.ya) <<< fbde_pkg::FRAC_W;
                end
                fbde_pkg::ST_DIV: begin
                    // one restoring step per cycle on |dy|<<16 / dx
                    if (r_dcnt == '0 && r_quo == '0) begin
                        r_quo <= {w_ady, {fbde_pkg::FRAC_W{1'b0}}};
                        r_neg <= (r_job.yb < r_job.ya);
                    end else begin
                        if (w_rem_sh >= {1'b0, w_dx}) begin
                            r_rem <= w_rem_sh - {1'b0, w_dx};
                            r_quo <= {r_quo[DIVW-2:0], 1'b1};
                        end else begin
                            r_rem <= w_rem_sh;
                            r_quo <= {r_quo[DIVW-2:0], 1'b0};
                        end
                        r_dcnt <= r_dcnt + 1'b1;
                        if (r_dcnt == DCW'(DIVW - 1))
                            r_slope <= r_neg ?
                                -SW'((w_rem_sh >= {1'b0, w_dx}) ?
                                     {r_quo[DIVW-2:0], 1'b1} : {r_quo[DIVW-2:0], 1'b0}) :
                                 SW'((w_rem_sh >= {1'b0, w_dx}) ?
                                     {r_quo[DIVW-2:0], 1'b1} : {r_quo[DIVW-2:0], 1'b0});
                    end
                end
                fbde_pkg::ST_MUL: begin
                    // row offset product, registered
                    case (r_job.kind)
                        fbde_pkg::JOB_VLINE: r_mul <= AW'(r_i) * AW'(i_eff_w);
                        fbde_pkg::JOB_SLINE: r_mul <= AW'(w_ypix) * AW'(i_eff_w);
                        default:             r_mul <= AW'(r_job.ya) * AW'(i_eff_w);
                    endcase
                end
                fbde_pkg::ST_ADDR: begin
                    r_addr <= r_mul + AW'((r_job.kind == fbde_pkg::JOB_VLINE) ? r_job.xa : r_i);
                end
                fbde_pkg::ST_RUN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_i != r_end) r_i <= r_i + 1'b1;
                    case (r_job.kind)
                        fbde_pkg::JOB_VLINE: r_addr <= r_addr + AW'(i_eff_w);
                        fbde_pkg::JOB_HLINE: r_addr <= r_addr + 1'b1;
                        fbde_pkg::JOB_SLINE: r_acc  <= r_acc + ACCW'(r_slope);
                        default:             r_addr <= r_addr;
                    endcase
                end
                fbde_pkg::ST_RDWAIT: r_ocolor <= r_rdata;
                fbde_pkg::ST_OUT:    r_ovalid <= 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- sv/fbde_checker.sv -----
// ============================================================================
// fbde_checker
// Port-level checks of the draw engine, bound to the top level.
// ============================================================================
module fbde_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic                          o_status,
    input logic [fbde_pkg::COLOR_W-1:0]  o_read_color,
    input logic                          o_stall
);

    // a result that waits keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_read_color))
        else $error("result changed while stalled");

    // out-of-range results never carry read data
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_read_color == '0)
        else $error("read data on out-of-range result");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // queue is empty after reset
    a_rst_stall: assert property (@(posedge i_clk) !i_rst_n |=> !o_stall)
        else $error("input stalled after reset");

endmodule

bind framebuffer_draw_engine_core fbde_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_status, .o_read_color, .o_stall
);

// ----- tb/sv/tb_top.sv -----
// ============================================================================
// tb_top
// Self-checking bench for the framebuffer draw engine core.
// ============================================================================
// Commands go in over the valid/stall channel, and results are taken off the
// output channel. A scoreboard keeps its own copy of the frame store and the
// screen size, and works out the status and read value for each command. It
// then compares them in order with what the core returns. The run steps
// through several screen sizes and through idle and stall patterns on both
// sides.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW  = 800;
    localparam int MAXH  = 600;
    localparam int CW    = fbde_pkg::COORD_W;
    localparam int CLW   = fbde_pkg::COLOR_W;
    localparam longint LIMIT = 4_000_000;

    typedef struct {
        fbde_pkg::t_opcode   op;
        logic [CW-1:0]       xs, ys, xe, ye;
        logic [CLW-1:0]      col;
    } t_cmd;

    typedef struct {
        logic                status;
        logic [CLW-1:0]      rd;
    } t_res;

    // Shadow frame store plus the queue of pending results
    class fb_scoreboard;
        logic [7:0]  pix[MAXW*MAXH];
        int          width = 800, height = 600;
        t_res        pending[$];
        int          errors = 0;

        function new();
            foreach (pix[i]) pix[i] = 8'h00;
        endfunction

        function int ew();
            return (width > MAXW) ? MAXW : width;
        endfunction

        function int eh();
            return (height > MAXH) ? MAXH : height;
        endfunction

        function bit on_scr(int x, int y);
            return x < ew() && y < eh();
        endfunction

        function void plot(int x, int y, logic [7:0] c);
            pix[x + y*ew()] = c;
        endfunction

        function void trace(int xa, int ya, int xb, int yb, logic [7:0] c);
            int     t, lo, hi;
            longint dy, dx, slope, acc;
            if (xb < xa) begin
                t = xa; xa = xb; xb = t;
                t = ya; ya = yb; yb = t;
            end
            if (xa == xb) begin
                lo = (ya < yb) ? ya : yb;
                hi = (ya < yb) ? yb : ya;
                for (int i = lo; i <= hi; i++) plot(xa, i, c);
                return;
            end
            if (ya == yb) begin
                for (int i = xa; i <= xb; i++) plot(i, ya, c);
                return;
            end
            dy = longint'(yb) - longint'(ya);
            dx = longint'(xb) - longint'(xa);
            slope = (dy * 65536) / dx;
            for (int i = xa; i <= xb; i++) begin
                acc = longint'(ya) * 65536 + slope * longint'(i - xa);
                if (acc < 0) acc = 0;
                plot(i, int'(acc >>> 16), c);
            end
        endfunction

        // accepted command: update shadow store, queue the expected result
        function void note_cmd(t_cmd c);
            t_res r;
            int   n;
            r.status = 1'b0;
            r.rd     = 8'h00;
            case (c.op)
                fbde_pkg::OP_FILL: begin
                    n = ew() * eh();
                    for (int i = 0; i < n; i++) pix[i] = c.col;
                end
                fbde_pkg::OP_SET: begin
                    if (on_scr(int'(c.xs), int'(c.ys))) plot(int'(c.xs), int'(c.ys), c.col);
                    else r.status = 1'b1;
                end
                fbde_pkg::OP_GET: begin
                    if (on_scr(int'(c.xs), int'(c.ys)))
                        r.rd = pix[int'(c.xs) + int'(c.ys)*ew()];
                    else r.status = 1'b1;
                end
                default: begin
                    if (on_scr(int'(c.xs), int'(c.ys)) && on_scr(int'(c.xe), int'(c.ye)))
                        trace(int'(c.xs), int'(c.ys), int'(c.xe), int'(c.ye), c.col);
                    else
                        r.status = 1'b1;
                end
            endcase
            pending.push_back(r);
        endfunction

        // accepted result: compare with oldest expectation
        function void check_res(logic status, logic [7:0] rd);
            t_res e;
            if (pending.size() == 0) begin
                $error("unexpected result status=%0d read_color=%0h", status, rd);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, status);
                errors++;
            end
            if (rd !== e.rd) begin
                $error("read_color: expected %0h, got %0h", e.rd, rd);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [1:0]          i_opcode = '0;
    logic [CW-1:0]       i_x_start = '0, i_y_start = '0, i_x_end = '0, i_y_end = '0;
    logic [CLW-1:0]      i_color = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic                o_status;
    logic [CLW-1:0]      o_read_color;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_index = 1'b0;
    logic [CW-1:0]       i_cfg_data = '0;

    fb_scoreboard sb = new();
    int     tx_idle_pct = 0;
    int     rx_stall_pct = 0;
    longint cycles = 0;

    framebuffer_draw_engine_core DUT (.*);

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // result side: check transfers, randomize stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_res(o_status, o_read_color);
        i_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    task automatic send_cmd(t_cmd c);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_opcode  <= c.op;
        i_x_start <= c.xs;
        i_y_start <= c.ys;
        i_x_end   <= c.xe;
        i_y_end   <= c.ye;
        i_color   <= c.col;
        do @(posedge i_clk); while (o_stall);
        sb.note_cmd(c);
    endtask

    task automatic send(fbde_pkg::t_opcode op, int xs, int ys, int xe, int ye, int col);
        t_cmd c;
        c.op = op;
        c.xs = CW'(xs);
        c.ys = CW'(ys);
        c.xe = CW'(xe);
        c.ye = CW'(ye);
        c.col = CLW'(col);
        send_cmd(c);
    endtask

    // drain, then write one register while the core is idle
    task automatic write_reg(logic idx, int val);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CW'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == fbde_pkg::REG_WIDTH) sb.width = val & 'h3FF;
        else sb.height = val & 'h3FF;
    endtask

    function automatic int coord(int lim);
        if (lim == 0 || $urandom_range(0, 99) < 12) return $urandom_range(0, 1023);
        return $urandom_range(0, lim - 1);
    endfunction

    function automatic t_cmd rand_cmd();
        t_cmd c;
        int   r, w, h;
        w = sb.ew();
        h = sb.eh();
        r = $urandom_range(0, 99);
        if (r < 4 && w * h <= 5000) c.op = fbde_pkg::OP_FILL;
        else if (r < 35) c.op = fbde_pkg::OP_SET;
        else if (r < 70) c.op = fbde_pkg::OP_GET;
        else c.op = fbde_pkg::OP_LINE;
        c.xs = CW'(coord(w));
        c.ys = CW'(coord(h));
        c.col = CLW'($urandom_range(0, 255));
        // keep most lines short on wide screens
        if (w > 64 && $urandom_range(0, 3) != 0) begin
            c.xe = CW'((int'(c.xs) + int'($urandom_range(0, 40))) % 1024);
            c.ye = CW'((int'(c.ys) + int'($urandom_range(0, 40))) % 1024);
        end else begin
            c.xe = CW'(coord(w));
            c.ye = CW'(coord(h));
        end
        r = $urandom_range(0, 9);
        if (r == 0) c.xe = c.xs;
        else if (r == 1) c.ye = c.ys;
        return c;
    endfunction

    int widths[7]  = '{16, 800, 1, 1023, 3, 0, 37};
    int heights[7] = '{12, 600, 1, 2, 1023, 7, 29};

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: corners, range edges and line shapes at reset size, then a 4x3 screen
        send(fbde_pkg::OP_SET, 0, 0, 0, 0, 255);
        send(fbde_pkg::OP_GET, 0, 0, 0, 0, 0);
        send(fbde_pkg::OP_SET, 799, 599, 0, 0, 'hAA);
        send(fbde_pkg::OP_GET, 799, 599, 0, 0, 0);
        send(fbde_pkg::OP_GET, 800, 0, 0, 0, 0);
        send(fbde_pkg::OP_GET, 0, 600, 0, 0, 0);
        send(fbde_pkg::OP_SET, 1023, 1023, 0, 0, 'h55);
        send(fbde_pkg::OP_LINE, 10, 10, 800, 10, 7);
        send(fbde_pkg::OP_LINE, 10, 10, 20, 1023, 7);
        send(fbde_pkg::OP_LINE, 799, 599, 0, 599, 'h11);
        send(fbde_pkg::OP_LINE, 799, 0, 799, 599, 'h22);
        send(fbde_pkg::OP_LINE, 5, 5, 5, 5, 'h33);
        send(fbde_pkg::OP_LINE, 700, 10, 3, 500, 'h44);
        send(fbde_pkg::OP_LINE, 0, 599, 5, 0, 'h66);
        send(fbde_pkg::OP_GET, 5, 5, 0, 0, 0);
        send(fbde_pkg::OP_GET, 0, 599, 0, 0, 0);
        send(fbde_pkg::OP_GET, 700, 10, 0, 0, 0);
        write_reg(fbde_pkg::REG_WIDTH, 4);
        write_reg(fbde_pkg::REG_HEIGHT, 3);
        send(fbde_pkg::OP_FILL, 0, 0, 0, 0, 'h5A);
        send(fbde_pkg::OP_GET, 3, 2, 0, 0, 0);
        send(fbde_pkg::OP_SET, 4, 0, 0, 0, 1);
        send(fbde_pkg::OP_LINE, 3, 0, 0, 2, 'hFF);
        send(fbde_pkg::OP_GET, 0, 2, 0, 0, 0);

        // random: each screen size under the four idle and stall patterns
        for (int s = 0; s < 7; s++) begin
            write_reg(fbde_pkg::REG_WIDTH, widths[s]);
            write_reg(fbde_pkg::REG_HEIGHT, heights[s]);
            for (int p = 0; p < 4; p++) begin
                tx_idle_pct  = (p == 1) ? 77 : (p == 3) ? 33 : 0;
                rx_stall_pct = (p == 2) ? 77 : (p == 3) ? 33 : 0;
                repeat (47) send_cmd(rand_cmd());
            end
        end
        i_valid <= 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
sv/fbde_pkg.sv
sv/fbde_front.sv
sv/fbde_back.sv
sv/framebuffer_draw_engine_core.sv
sv/fbde_checker.sv
tb/sv/tb_top.sv
